### src/mdr_pkg.sv
// ----------------------------------------------------------------------------
// mdr_pkg: shared types and constants for the masked distance reduction
// Holds the pixel and result formats, the mode codes, the controller states
// and the command and status groups that join the controller and datapath.
// ----------------------------------------------------------------------------
package mdr_pkg;

    // Field widths fixed by the pixel and result formats.
    localparam int DIST_W  = 16;
    localparam int SCALE_W = 12;
    localparam int VAL_W   = 20;
    localparam int MODE_W  = 2;
    localparam int FRAC_SHIFT = 8;

    // Default image size bound, as log2 of the pixel count.
    localparam int MAX_PIXELS_LOG2_DEF = 20;

    // Reset value of the scale register: 1.0 in Q4.8.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;

    // Mode register codes.
    localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAW = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDX_MODE  = 1'b0;
    localparam logic CFG_IDX_SCALE = 1'b1;

    // One input pixel.
    typedef struct packed {
        logic              in_mask;
        logic [DIST_W-1:0] distance;
        logic              end_of_image;
    } pix_t;

    // One result item.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             has_value;
        logic             final_res;
    } res_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic div_start;
        logic div_step;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              mask;
        logic              last;
        logic              div_last;
        logic              out_free;
    } sts_t;

endpackage

### src/mdr_ctrl.sv
// ----------------------------------------------------------------------------
// mdr_ctrl: sequencing state machine for the masked distance reduction
// Steps each pixel through scaling, accumulation, the optional division of
// the mean and the hand-off into the result register.
// ----------------------------------------------------------------------------
module mdr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pix_valid,
    output logic           pix_stall,
    input  mdr_pkg::sts_t  sts,
    output mdr_pkg::cmd_t  cmd
);
    import mdr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   need_emit;
    logic   need_div;

    // Decisions taken once the sample has been accumulated.
    assign need_div  = sts.last && (sts.mode == MODE_AVG);
    assign need_emit = sts.last || ((sts.mode == MODE_RAW) && sts.mask);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (need_div)
                begin
                    state_next = ST_DIV;
                end
                else if (need_emit)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        pix_stall     = (state_reg != ST_IDLE);
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && pix_valid;
        cmd.mul       = (state_reg == ST_MUL);
        cmd.acc       = (state_reg == ST_ACC);
        cmd.div_start = (state_reg == ST_ACC) && need_div;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.emit      = (state_reg == ST_EMIT) && sts.out_free;
    end

    // A result that cannot be handed over keeps the machine waiting for it.
    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !sts.out_free) |=> (state_reg == ST_EMIT))
        else $error("result dropped while output register was busy");

    // The divider is only entered from accumulation.
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ($past(state_reg) == ST_ACC || $past(state_reg) == ST_DIV))
        else $error("divider entered without accumulation");

endmodule

### src/mdr_datapath.sv
// ----------------------------------------------------------------------------
// mdr_datapath: arithmetic of the masked distance reduction
// Holds the configuration registers, the scaling multiplier, the sum, count
// and maximum accumulators, a one-bit-per-cycle divider for the mean and the
// result register.
// ----------------------------------------------------------------------------
module mdr_datapath #(
    parameter int MAX_PIXELS_LOG2 = mdr_pkg::MAX_PIXELS_LOG2_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_index,
    input  logic [mdr_pkg::SCALE_W-1:0]   cfg_wdata,
    input  mdr_pkg::pix_t                 pix,
    output logic                          res_valid,
    input  logic                          res_stall,
    output mdr_pkg::res_t                 res,
    input  mdr_pkg::cmd_t                 cmd,
    output mdr_pkg::sts_t                 sts
);
    import mdr_pkg::*;

    localparam int SUM_W  = MAX_PIXELS_LOG2 + VAL_W;
    localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
    localparam int PROD_W = DIST_W + SCALE_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    // Configuration.
    logic [MODE_W-1:0]  mode_reg;
    logic [SCALE_W-1:0] scale_reg;

    // Captured pixel and scaled sample.
    logic              mask_reg;
    logic              last_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [VAL_W-1:0]  scaled_reg;
    logic [PROD_W-1:0] product;

    // Accumulators.
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] max_reg, max_next;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0] count_acc;
    logic [VAL_W-1:0] max_acc;

    // Divider.
    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CNT_W:0]    rem_shift;
    logic              rem_ge;
    logic [VAL_W-1:0]  mean;

    // Result register.
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg;
    res_t             res_build;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_AVG;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == CFG_IDX_MODE)
            begin
                mode_reg <= cfg_wdata[MODE_W-1:0];
            end
            else
            begin
                scale_reg <= cfg_wdata;
            end
        end
    end

    // Pixel capture and scaling. The Q12.4 by Q4.8 product shifted right
    // by eight always fits in 20 bits, so no clamp is needed.
    assign product = PROD_W'(dist_reg) * PROD_W'(scale_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mask_reg <= pix.in_mask;
            last_reg <= pix.end_of_image;
            dist_reg <= pix.distance;
        end
        if (cmd.mul)
        begin
            scaled_reg <= product[PROD_W-1:FRAC_SHIFT];
        end
    end

    // Saturating accumulation of a masked sample.
    assign sum_ext   = {1'b0, sum_reg} + (SUM_W+1)'(scaled_reg);
    assign sum_acc   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign count_acc = (&count_reg) ? count_reg : count_reg + CNT_W'(1);
    assign max_acc   = (scaled_reg > max_reg) ? scaled_reg : max_reg;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        max_next   = max_reg;
        if (cmd.acc && mask_reg)
        begin
            sum_next   = sum_acc;
            count_next = count_acc;
            max_next   = max_acc;
        end
        else if (cmd.emit && last_reg)
        begin
            sum_next   = '0;
            count_next = '0;
            max_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            max_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            max_reg   <= max_next;
        end
    end

    // Restoring divider: one quotient bit per cycle, the dividend shifting
    // out of the top of the quotient register as quotient bits enter below.
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count_reg});

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        if (cmd.div_start)
        begin
            quot_next = sum_next;
            rem_next  = '0;
            dcnt_next = DCNT_W'(SUM_W);
        end
        else if (cmd.div_step)
        begin
            quot_next = {quot_reg[SUM_W-2:0], rem_ge};
            rem_next  = rem_ge ? CNT_W'(rem_shift - {1'b0, count_reg})
                               : rem_shift[CNT_W-1:0];
            dcnt_next = dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
    end

    // The mean clamps to 20 bits and is zero over an empty mask.
    always_comb
    begin
        if (count_reg == '0)
        begin
            mean = '0;
        end
        else if (|quot_reg[SUM_W-1:VAL_W])
        begin
            mean = {VAL_W{1'b1}};
        end
        else
        begin
            mean = quot_reg[VAL_W-1:0];
        end
    end

    // Result selection by mode.
    always_comb
    begin
        res_build           = '0;
        res_build.final_res = last_reg;
        case (mode_reg)
            MODE_AVG:
            begin
                res_build.value     = mean;
                res_build.has_value = 1'b1;
            end
            MODE_MAX:
            begin
                res_build.value     = max_reg;
                res_build.has_value = 1'b1;
            end
            MODE_RAW:
            begin
                res_build.value     = mask_reg ? scaled_reg : '0;
                res_build.has_value = mask_reg;
            end
            default:
            begin
                res_build.value     = '0;
                res_build.has_value = 1'b0;
            end
        endcase
    end

    // Output register: loaded on emit, emptied when the receiver takes it.
    assign res_valid_next = cmd.emit ? 1'b1 : (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_build;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Status back to the controller.
    always_comb
    begin
        sts          = '0;
        sts.mode     = mode_reg;
        sts.mask     = mask_reg;
        sts.last     = last_reg;
        sts.div_last = (dcnt_reg == DCNT_W'(1));
        sts.out_free = !res_valid_reg || !res_stall;
    end

    // The last pixel's result leaves the accumulators cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && last_reg) |=> (sum_reg == '0 && count_reg == '0 && max_reg == '0))
        else $error("accumulators not cleared after last pixel");

    // An empty mask can hold no sum.
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("sum without masked pixels");

    // The maximum never exceeds the sum of the samples it came from.
    a_max_le_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(max_reg) <= sum_reg))
        else $error("running maximum above running sum");

endmodule

### src/masked_distance_reduce.sv
// ----------------------------------------------------------------------------
// masked_distance_reduce: masked mean, maximum or raw scaled distance stream
// Scales each distance sample and reduces the masked ones over an image.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel items enter on pix / pix_valid / pix_stall; result items leave on
//   res / res_valid / res_stall. An item moves when valid is high and stall
//   is low. Mode and scale are written through cfg_write_en / cfg_index /
//   cfg_wdata while no pixel is in flight.
//   Each pixel passes through capture, multiply and accumulate before the
//   next can be accepted, and through emit as well when it produces a result;
//   emit waits while the result register holds a result not yet taken. In
//   average mode the last pixel of an image also runs the serial divider, one
//   quotient bit per cycle. A result is registered once its pixel has passed
//   through emit, after the divider for a mean.
//   The result register decouples the two sides: while a result waits under
//   stall, the next pixel is still accepted and processed; the block only
//   holds when a second result is ready before the first has been taken.
//   Reset clears the accumulators, sets mode to average and scale to 1.0,
//   and empties the result register.
// ----------------------------------------------------------------------------
module masked_distance_reduce #(
    parameter int MAX_PIXELS_LOG2 = mdr_pkg::MAX_PIXELS_LOG2_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic                        cfg_index,
    input  logic [mdr_pkg::SCALE_W-1:0] cfg_wdata,
    input  logic                        pix_valid,
    output logic                        pix_stall,
    input  mdr_pkg::pix_t               pix,
    output logic                        res_valid,
    input  logic                        res_stall,
    output mdr_pkg::res_t               res
);
    import mdr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing.
    mdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and result register.
    mdr_datapath #(
        .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .pix          (pix),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
